### design/clci_pkg.sv
package clci_pkg;

   localparam int MaxLanes   = 8;
   localparam int DepthWidth = 48;
   localparam int ValueWidth = 32;
   localparam int QFrac      = 24;
   localparam int QWidth     = QFrac + 1;
   localparam int DiffWidth  = DepthWidth + 1;
   localparam int DefLanes   = 8;
   localparam logic [DepthWidth-1:0] LevelReset = 48'h0100_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_BLEND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic start_div;
      logic div_step;
      logic blend_lane;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic crossing;
      logic col_end;
      logic div_done;
      logic lane_last;
   } status_type;

endpackage

### design/clci_datapath.sv
module clci_datapath #(
   parameter int LANES = clci_pkg::DefLanes
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  clci_pkg::cmd_type                         cmd,
   output clci_pkg::status_type                      status,
   input  logic [clci_pkg::DepthWidth-1:0]           level,
   input  logic [clci_pkg::DepthWidth-1:0]           in_depth,
   input  logic [clci_pkg::MaxLanes*clci_pkg::ValueWidth-1:0] in_values,
   input  logic                                      in_end,
   output logic [clci_pkg::MaxLanes*clci_pkg::ValueWidth-1:0] out_values,
   output logic                                      out_found
);
   import clci_pkg::*;

   localparam int LaneBits = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int StepBits = $clog2(QFrac + 1);
   localparam int ProdWidth = ValueWidth + 1 + QWidth + 1;

   logic [DepthWidth-1:0] prior_depth_ff;
   logic [ValueWidth-1:0] prior_ff [MaxLanes];
   logic [ValueWidth-1:0] cur_ff [MaxLanes];
   logic [ValueWidth-1:0] held_ff [MaxLanes];
   logic                  have_prior_ff;
   logic                  found_ff;
   logic                  end_ff;
   logic [DepthWidth-1:0] den_ff;
   logic [DiffWidth-1:0]  rem_ff;
   logic [QWidth-1:0]     q_ff;
   logic [StepBits-1:0]   step_ff;
   logic [LaneBits-1:0]   lane_ff;

   logic [DepthWidth-1:0] cur_depth_ff;
   logic [DiffWidth-1:0]  rem_sh;
   logic                  ge;
   logic signed [ValueWidth:0]     diff;
   logic signed [ProdWidth-1:0]    prod;
   logic signed [ProdWidth-1:0]    res;
   logic [ValueWidth-1:0]          sat;

   assign status.crossing = have_prior_ff && (prior_depth_ff >= level) && (level > cur_depth_ff);
   assign status.col_end  = end_ff;
   assign status.div_done = (step_ff == StepBits'(QFrac));
   assign status.lane_last = (lane_ff == LaneBits'(LANES - 1));

   assign rem_sh = {rem_ff[DiffWidth-2:0], 1'b0};
   assign ge     = rem_sh >= {1'b0, den_ff};

   assign diff = $signed({prior_ff[lane_ff][ValueWidth-1], prior_ff[lane_ff]})
               - $signed({cur_ff[lane_ff][ValueWidth-1], cur_ff[lane_ff]});
   assign prod = ProdWidth'(diff * $signed({1'b0, q_ff}))
               + ProdWidth'(1 << (QFrac - 1));
   assign res  = ProdWidth'($signed(cur_ff[lane_ff])) + (prod >>> QFrac);

   always_comb begin
      if (res > ProdWidth'(32'sh7fff_ffff)) begin
         sat = 32'h7fff_ffff;
      end else if (res < -ProdWidth'(64'sh8000_0000)) begin
         sat = 32'h8000_0000;
      end else begin
         sat = res[ValueWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prior_ff <= 1'b0;
         found_ff      <= 1'b0;
         end_ff        <= 1'b0;
         step_ff       <= '0;
         lane_ff       <= '0;
         prior_depth_ff <= '0;
         cur_depth_ff  <= '0;
         for (int i = 0; i < MaxLanes; i++) begin
            held_ff[i]  <= '0;
            prior_ff[i] <= '0;
         end
      end else begin
         if (cmd.take) begin
            cur_depth_ff <= in_depth;
            end_ff       <= in_end;
            for (int i = 0; i < MaxLanes; i++) begin
               cur_ff[i] <= in_values[i*ValueWidth +: ValueWidth];
            end
         end
         if (cmd.start_div) begin
            den_ff  <= prior_depth_ff - cur_depth_ff;
            rem_ff  <= ((level - cur_depth_ff) >= (prior_depth_ff - cur_depth_ff))
                       ? {1'b0, (level - cur_depth_ff) - (prior_depth_ff - cur_depth_ff)}
                       : {1'b0, level - cur_depth_ff};
            q_ff    <= ((level - cur_depth_ff) >= (prior_depth_ff - cur_depth_ff))
                       ? QWidth'(1) : '0;
            step_ff <= '0;
            lane_ff <= '0;
         end
         if (cmd.div_step) begin
            rem_ff  <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
            q_ff    <= {q_ff[QWidth-2:0], ge};
            step_ff <= step_ff + StepBits'(1);
         end
         if (cmd.blend_lane) begin
            held_ff[lane_ff] <= sat;
            lane_ff  <= lane_ff + LaneBits'(1);
            found_ff <= 1'b1;
         end
         if (cmd.clear) begin
            if (end_ff) begin
               have_prior_ff  <= 1'b0;
               prior_depth_ff <= '0;
               found_ff       <= 1'b0;
               for (int i = 0; i < MaxLanes; i++) begin
                  prior_ff[i] <= '0;
                  held_ff[i]  <= '0;
               end
            end else begin
               have_prior_ff  <= 1'b1;
               prior_depth_ff <= cur_depth_ff;
               for (int i = 0; i < MaxLanes; i++) begin
                  prior_ff[i] <= cur_ff[i];
               end
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MaxLanes; i++) begin
         out_values[i*ValueWidth +: ValueWidth] = (i < LANES) ? held_ff[i] : '0;
      end
   end
   assign out_found = found_ff;

endmodule

### design/clci_control.sv
module clci_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  clci_pkg::status_type status,
   output clci_pkg::cmd_type    cmd
);
   import clci_pkg::*;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Finishing a cell: crossing work or straight to commit.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (busy_ff) state_in = status.crossing ? ST_DIV : ST_EMIT;
         ST_DIV:   if (status.div_done) state_in = ST_BLEND;
         ST_BLEND: if (status.lane_last) state_in = ST_EMIT;
         ST_EMIT:  if (!(status.col_end && rsp_valid_ff)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.take = req_valid && !req_stall;
      unique case (state_ff)
         ST_IDLE:  cmd.start_div = busy_ff && status.crossing;
         ST_DIV:   cmd.div_step = !status.div_done;
         ST_BLEND: cmd.blend_lane = 1'b1;
         ST_EMIT: begin
            cmd.emit  = !(status.col_end && rsp_valid_ff);
            cmd.clear = cmd.emit;
         end
         default: ;
      endcase
   end

   assign req_stall    = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (cmd.emit && status.col_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.take) begin
            busy_ff <= 1'b1;
         end else if (cmd.clear) begin
            busy_ff <= 1'b0;
         end
      end
   end

endmodule

### design/column_level_crossing_interp.sv
// Level-crossing interpolator, one column of cells at a time.
// The req_ channel takes one beat per cell: depth, value_0..value_7 and
// column_end. The csr_ channel writes the slice level; write it only while idle.
// A cell without a crossing goes from idle straight to emit. A cell with a
// crossing first runs the bit-serial Q1.24 divider and then the
// single shared blend multiplier that handles one lane per cycle.
// The rsp_ channel carries one beat on each column's final cell, holding the
// interpolated lanes and crossing_found, in the cycle after that cell finishes.
// The result sits in an output register, so the next cell is taken while it
// waits. When the receiver stalls with a result still held, a further
// column end waits until that result is taken.
// Reset clears the held slice, the previous cell and the flag, and sets
// the level back to 1.0 in Q8.40.
module column_level_crossing_interp #(
   parameter int LANES = clci_pkg::DefLanes
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [clci_pkg::DepthWidth-1:0]  csr_depth_level,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [clci_pkg::DepthWidth-1:0]  req_depth,
   input  logic signed [31:0]               req_value_0,
   input  logic signed [31:0]               req_value_1,
   input  logic signed [31:0]               req_value_2,
   input  logic signed [31:0]               req_value_3,
   input  logic signed [31:0]               req_value_4,
   input  logic signed [31:0]               req_value_5,
   input  logic signed [31:0]               req_value_6,
   input  logic signed [31:0]               req_value_7,
   input  logic                             req_column_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_slice_0,
   output logic signed [31:0]               rsp_slice_1,
   output logic signed [31:0]               rsp_slice_2,
   output logic signed [31:0]               rsp_slice_3,
   output logic signed [31:0]               rsp_slice_4,
   output logic signed [31:0]               rsp_slice_5,
   output logic signed [31:0]               rsp_slice_6,
   output logic signed [31:0]               rsp_slice_7,
   output logic                             rsp_crossing_found
);
   import clci_pkg::*;

   logic [DepthWidth-1:0]          level_ff;
   cmd_type                        cmd;
   status_type                     status;
   logic [MaxLanes*ValueWidth-1:0] in_values;
   logic [MaxLanes*ValueWidth-1:0] dp_values;
   logic                           dp_found;
   logic [MaxLanes*ValueWidth-1:0] rsp_values_ff;
   logic                           rsp_found_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LevelReset;
      end else if (csr_valid && csr_ready) begin
         level_ff <= csr_depth_level;
      end
   end

   assign in_values = {req_value_7, req_value_6, req_value_5, req_value_4,
                       req_value_3, req_value_2, req_value_1, req_value_0};

   clci_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   clci_datapath #(.LANES(LANES)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .level      (level_ff),
      .in_depth   (req_depth),
      .in_values  (in_values),
      .in_end     (req_column_end),
      .out_values (dp_values),
      .out_found  (dp_found)
   );

   always_ff @(posedge clock) begin
      if (cmd.emit && status.col_end) begin
         rsp_values_ff <= dp_values;
         rsp_found_ff  <= dp_found;
      end
   end

   assign rsp_slice_0 = rsp_values_ff[0*ValueWidth +: ValueWidth];
   assign rsp_slice_1 = rsp_values_ff[1*ValueWidth +: ValueWidth];
   assign rsp_slice_2 = rsp_values_ff[2*ValueWidth +: ValueWidth];
   assign rsp_slice_3 = rsp_values_ff[3*ValueWidth +: ValueWidth];
   assign rsp_slice_4 = rsp_values_ff[4*ValueWidth +: ValueWidth];
   assign rsp_slice_5 = rsp_values_ff[5*ValueWidth +: ValueWidth];
   assign rsp_slice_6 = rsp_values_ff[6*ValueWidth +: ValueWidth];
   assign rsp_slice_7 = rsp_values_ff[7*ValueWidth +: ValueWidth];
   assign rsp_crossing_found = rsp_found_ff;

`ifndef SYNTHESIS
   a_emit_not_over: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("held result dropped");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> req_stall)
      else $error("cell taken during divide");
   a_stall_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> req_stall)
      else $error("stall missing after take");
`endif

endmodule

### tb/column_level_crossing_interp_checker.sv
module column_level_crossing_interp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [clci_pkg::DepthWidth-1:0]  csr_depth_level,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [clci_pkg::DepthWidth-1:0]  req_depth,
   input  logic signed [31:0]               req_value_0,
   input  logic signed [31:0]               req_value_1,
   input  logic signed [31:0]               req_value_2,
   input  logic signed [31:0]               req_value_3,
   input  logic signed [31:0]               req_value_4,
   input  logic signed [31:0]               req_value_5,
   input  logic signed [31:0]               req_value_6,
   input  logic signed [31:0]               req_value_7,
   input  logic                             req_column_end,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [31:0]               rsp_slice_0,
   input  logic signed [31:0]               rsp_slice_1,
   input  logic signed [31:0]               rsp_slice_2,
   input  logic signed [31:0]               rsp_slice_3,
   input  logic signed [31:0]               rsp_slice_4,
   input  logic signed [31:0]               rsp_slice_5,
   input  logic signed [31:0]               rsp_slice_6,
   input  logic signed [31:0]               rsp_slice_7,
   input  logic                             rsp_crossing_found,
   output int                               error_count,
   output int                               pending_slices
);
   import clci_pkg::*;

   typedef struct packed {
      logic [MaxLanes-1:0][31:0] lanes;
      logic                      found;
   } slice_type;

   logic [DepthWidth-1:0]     level;
   logic [DepthWidth-1:0]     last_depth;
   logic [MaxLanes-1:0][31:0] last_values;
   logic                      has_last;
   logic [MaxLanes-1:0][31:0] held;
   logic                      held_found;
   slice_type                 slice_queue[$];

   function automatic logic [24:0] depth_ratio(logic [DepthWidth-1:0] num,
                                                logic [DepthWidth-1:0] den);
      logic [DepthWidth+24:0] wide;
      wide = {num, 24'd0};
      return 25'(wide / den);
   endfunction

   function automatic logic [31:0] lerp_lane(logic signed [31:0] cur,
                                             logic signed [31:0] prev,
                                             logic [24:0] q);
      logic signed [63:0] diff;
      logic signed [63:0] prod;
      logic signed [63:0] res;
      diff = 64'(prev) - 64'(cur);
      prod = diff * $signed({39'd0, q}) + 64'sd8388608;
      res = 64'(cur) + (prod >>> 24);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return res[31:0];
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      logic [MaxLanes-1:0][31:0] cur;
      logic [MaxLanes-1:0][31:0] got;
      logic [24:0]               q;
      slice_type                 want;
      if (reset) begin
         level <= LevelReset;
         last_depth = '0;
         last_values = '0;
         has_last = 0;
         held = '0;
         held_found = 0;
         slice_queue.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) level <= csr_depth_level;
         if (req_valid && !req_stall) begin
            cur = {req_value_7, req_value_6, req_value_5, req_value_4,
                   req_value_3, req_value_2, req_value_1, req_value_0};
            if (has_last && last_depth >= level && level > req_depth) begin
               q = depth_ratio(level - req_depth, last_depth - req_depth);
               for (int l = 0; l < MaxLanes; l++)
                  held[l] = lerp_lane(cur[l], last_values[l], q);
               held_found = 1;
            end
            last_depth = req_depth;
            last_values = cur;
            has_last = 1;
            if (req_column_end) begin
               slice_queue.push_back({held, held_found});
               held = '0;
               held_found = 0;
               has_last = 0;
               last_depth = '0;
               last_values = '0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_slice_7, rsp_slice_6, rsp_slice_5, rsp_slice_4,
                   rsp_slice_3, rsp_slice_2, rsp_slice_1, rsp_slice_0};
            if (slice_queue.size() == 0) begin
               $display("%0t: slice beat with none expected", $time);
               error_count++;
            end else begin
               want = slice_queue.pop_front();
               for (int l = 0; l < MaxLanes; l++)
                  if (got[l] !== want.lanes[l])
                     report_mismatch($sformatf("slice_%0d", l), got[l], want.lanes[l]);
               if (rsp_crossing_found !== want.found)
                  report_mismatch("crossing_found", rsp_crossing_found, want.found);
            end
         end
      end
      pending_slices = slice_queue.size();
   end
endmodule

### tb/column_level_crossing_interp_test.sv
module column_level_crossing_interp_test;
   import clci_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [DepthWidth-1:0] csr_depth_level = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [DepthWidth-1:0] req_depth = '0;
   logic signed [31:0] req_value [MaxLanes];
   logic req_column_end = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_slice [MaxLanes];
   logic rsp_crossing_found;
   int error_count;
   int pending_slices;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   logic [DepthWidth-1:0] level = LevelReset;

   initial foreach (req_value[l]) req_value[l] = '0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   column_level_crossing_interp u_dut (
      .clock, .reset, .csr_valid, .csr_ready, .csr_depth_level,
      .req_valid, .req_stall, .req_depth,
      .req_value_0(req_value[0]), .req_value_1(req_value[1]),
      .req_value_2(req_value[2]), .req_value_3(req_value[3]),
      .req_value_4(req_value[4]), .req_value_5(req_value[5]),
      .req_value_6(req_value[6]), .req_value_7(req_value[7]),
      .req_column_end, .rsp_valid, .rsp_stall,
      .rsp_slice_0(rsp_slice[0]), .rsp_slice_1(rsp_slice[1]),
      .rsp_slice_2(rsp_slice[2]), .rsp_slice_3(rsp_slice[3]),
      .rsp_slice_4(rsp_slice[4]), .rsp_slice_5(rsp_slice[5]),
      .rsp_slice_6(rsp_slice[6]), .rsp_slice_7(rsp_slice[7]),
      .rsp_crossing_found
   );

   column_level_crossing_interp_checker u_checker (
      .clock, .reset, .csr_valid, .csr_ready, .csr_depth_level,
      .req_valid, .req_stall, .req_depth,
      .req_value_0(req_value[0]), .req_value_1(req_value[1]),
      .req_value_2(req_value[2]), .req_value_3(req_value[3]),
      .req_value_4(req_value[4]), .req_value_5(req_value[5]),
      .req_value_6(req_value[6]), .req_value_7(req_value[7]),
      .req_column_end, .rsp_valid, .rsp_stall,
      .rsp_slice_0(rsp_slice[0]), .rsp_slice_1(rsp_slice[1]),
      .rsp_slice_2(rsp_slice[2]), .rsp_slice_3(rsp_slice[3]),
      .rsp_slice_4(rsp_slice[4]), .rsp_slice_5(rsp_slice[5]),
      .rsp_slice_6(rsp_slice[6]), .rsp_slice_7(rsp_slice[7]),
      .rsp_crossing_found, .error_count, .pending_slices
   );

   // The receiver stalls at random, or for a whole stretch while a hold is counted down.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [31:0] random_value();
      case ($urandom_range(5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DepthWidth-1:0] random_depth();
      case ($urandom_range(4))
         0: return 48'({$urandom, $urandom});
         1: return level;
         2: return level + 48'($urandom_range(3)) - 48'd1;
         default: return level + 48'($signed($urandom));
      endcase
   endfunction

   // Entered and left at a falling edge; the caller drops valid when it stops sending.
   task automatic send_cell(logic [DepthWidth-1:0] depth, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_depth <= depth;
      req_column_end <= last;
      foreach (req_value[l]) req_value[l] <= random_value();
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_column(int cells);
      for (int c = 0; c < cells; c++) send_cell(random_depth(), c == cells - 1);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_slices != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_level(logic [DepthWidth-1:0] value);
      drain();
      csr_valid <= 1;
      csr_depth_level <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
      level = value;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: single cell, exact level, extremes, descending crossings.
      send_cell(48'd0, 1);
      send_cell(LevelReset, 0);
      send_cell(LevelReset - 1, 1);
      send_cell(48'hffff_ffff_ffff, 0);
      send_cell(48'd0, 0);
      send_cell(48'hffff_ffff_ffff, 0);
      send_cell(48'd0, 1);
      send_cell(48'd0, 0);
      send_cell(48'hffff_ffff_ffff, 1);
      write_level(48'd0);
      send_column(4);
      write_level(48'hffff_ffff_ffff);
      send_cell(48'hffff_ffff_ffff, 0);
      send_cell(48'hffff_ffff_fffe, 1);
      send_column(3);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 22 : phase == 1 ? 61 : 0;
         recv_idle_pct = phase == 0 ? 61 : phase == 1 ? 22 : 0;
         write_level(phase == 2 ? LevelReset : 48'({$urandom, $urandom}));
         if (phase == 2) begin
            hold_cycles = 400;
            for (int c = 0; c < 12; c++) send_column(2);
            drain();
         end
         for (int k = 0; k < 135; k += 0) begin
            int cells;
            cells = $urandom_range(6, 1);
            send_column(cells);
            k += cells;
         end
      end
      drain();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #3000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
